/* rtl/nnd_pkg.sv */
// nnd_pkg: shared constants, register index codes and the sample flag struct
// for the nearest-neighbour downscaler; no dependencies
package nnd_pkg;

  // default fixed-point geometry
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;

  // fixed field widths
  localparam int PIX_W     = 24;
  localparam int CHAN_W    = 8;
  localparam int CFG_DIM_W = 13;
  localparam int CFG_IDX_W = 3;

  // register reset values
  localparam logic [CFG_DIM_W-1:0] SRC_W_RST = CFG_DIM_W'(640);
  localparam logic [CFG_DIM_W-1:0] SRC_H_RST = CFG_DIM_W'(480);
  localparam logic [CFG_DIM_W-1:0] OUT_W_RST = CFG_DIM_W'(320);
  localparam logic [CFG_DIM_W-1:0] OUT_H_RST = CFG_DIM_W'(240);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd1,
    REG_OUTPUT_WIDTH  = 3'd2,
    REG_OUTPUT_HEIGHT = 3'd3,
    REG_ROW_STEP      = 3'd4,
    REG_COLUMN_STEP   = 3'd5,
    REG_COLOR_MODE    = 3'd6
  } cfg_reg_t;

  // per-pixel decision from the sampler
  typedef struct packed {
    logic hit;
    logic row_end;
    logic frame_end;
  } sample_t;

endpackage

/* rtl/nnd_cfg_regs.sv */
// nnd_cfg_regs: configuration register file with clamping of dimensions and
// steps and the pre-rounded step values; depends on nnd_pkg
module nnd_cfg_regs #(
  parameter int COORD_BITS = nnd_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = nnd_pkg::FRAC_BITS_DEF,
  parameter int CFG_DATA_W = ((4 + FRAC_BITS) > nnd_pkg::CFG_DIM_W) ?
                             (4 + FRAC_BITS) : nnd_pkg::CFG_DIM_W
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [nnd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]               cfg_data,
  output logic [COORD_BITS-1:0]               src_w_m1,
  output logic [COORD_BITS-1:0]               src_h_m1,
  output logic [COORD_BITS:0]                 out_w,
  output logic [COORD_BITS:0]                 out_h,
  output logic [3+FRAC_BITS:0]                col_step,
  output logic [3+FRAC_BITS:0]                row_step,
  output logic [COORD_BITS+FRAC_BITS:0]       col_step_h,
  output logic [COORD_BITS+FRAC_BITS:0]       row_step_h,
  output logic                                color_mode
);
  import nnd_pkg::*;

  localparam int STEP_W  = 4 + FRAC_BITS;
  localparam int D_W     = COORD_BITS + 1;
  localparam int ACC_H_W = COORD_BITS + FRAC_BITS + 1;
  localparam int CMP_W   = (CFG_DIM_W > D_W) ? CFG_DIM_W : D_W;
  localparam logic [STEP_W-1:0]  STEP_ONE = STEP_W'(1) << FRAC_BITS;
  localparam logic [STEP_W-1:0]  STEP_RST = STEP_W'(2) << FRAC_BITS;
  localparam logic [ACC_H_W-1:0] HALF_H   = ACC_H_W'(1) << (FRAC_BITS - 1);
  localparam logic [CMP_W-1:0]   DIM_MAX  = CMP_W'(1) << COORD_BITS;

  logic [CFG_DIM_W-1:0] src_w_r, src_h_r, out_w_r, out_h_r;
  logic [STEP_W-1:0]    row_step_r, col_step_r;
  logic                 color_mode_r;

  // clamp a dimension to 1 .. 2^COORD_BITS
  function automatic logic [D_W-1:0] dim_of(input logic [CFG_DIM_W-1:0] v);
    logic [CMP_W-1:0] e;
    e = CMP_W'(v);
    if (e == '0) begin
      e = CMP_W'(1);
    end else if (e > DIM_MAX) begin
      e = DIM_MAX;
    end
    return e[D_W-1:0];
  endfunction

  // steps below one are used as one
  function automatic logic [STEP_W-1:0] step_of(input logic [STEP_W-1:0] v);
    return (v < STEP_ONE) ? STEP_ONE : v;
  endfunction

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r      <= SRC_W_RST;
      src_h_r      <= SRC_H_RST;
      out_w_r      <= OUT_W_RST;
      out_h_r      <= OUT_H_RST;
      row_step_r   <= STEP_RST;
      col_step_r   <= STEP_RST;
      color_mode_r <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SOURCE_WIDTH:  src_w_r      <= cfg_data[CFG_DIM_W-1:0];
        REG_SOURCE_HEIGHT: src_h_r      <= cfg_data[CFG_DIM_W-1:0];
        REG_OUTPUT_WIDTH:  out_w_r      <= cfg_data[CFG_DIM_W-1:0];
        REG_OUTPUT_HEIGHT: out_h_r      <= cfg_data[CFG_DIM_W-1:0];
        REG_ROW_STEP:      row_step_r   <= cfg_data[STEP_W-1:0];
        REG_COLUMN_STEP:   col_step_r   <= cfg_data[STEP_W-1:0];
        REG_COLOR_MODE:    color_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [D_W-1:0] src_w_c, src_h_c;

  // derived values used by the sampler
  always_comb begin
    src_w_c    = dim_of(src_w_r);
    src_h_c    = dim_of(src_h_r);
    src_w_m1   = COORD_BITS'(src_w_c - D_W'(1));
    src_h_m1   = COORD_BITS'(src_h_c - D_W'(1));
    out_w      = dim_of(out_w_r);
    out_h      = dim_of(out_h_r);
    col_step   = step_of(col_step_r);
    row_step   = step_of(row_step_r);
    col_step_h = ACC_H_W'(col_step) + HALF_H;
    row_step_h = ACC_H_W'(row_step) + HALF_H;
    color_mode = color_mode_r;
  end

endmodule

/* rtl/nnd_sampler.sv */
// nnd_sampler: raster position counters, sampling accumulators and the hit
// decision for one pixel a cycle while step_en is high; depends on nnd_pkg
module nnd_sampler #(
  parameter int COORD_BITS = nnd_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = nnd_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_en,
  input  logic                          frame_start,
  input  logic [COORD_BITS-1:0]         src_w_m1,
  input  logic [COORD_BITS-1:0]         src_h_m1,
  input  logic [COORD_BITS:0]           out_w,
  input  logic [COORD_BITS:0]           out_h,
  input  logic [3+FRAC_BITS:0]          col_step,
  input  logic [3+FRAC_BITS:0]          row_step,
  input  logic [COORD_BITS+FRAC_BITS:0] col_step_h,
  input  logic [COORD_BITS+FRAC_BITS:0] row_step_h,
  output nnd_pkg::sample_t              res
);
  import nnd_pkg::*;

  localparam int STEP_W  = 4 + FRAC_BITS;
  localparam int ACC_W   = COORD_BITS + FRAC_BITS;
  localparam int ACC_H_W = ACC_W + 1;
  localparam int D_W     = COORD_BITS + 1;
  localparam logic [ACC_H_W-1:0] HALF_H    = ACC_H_W'(1) << (FRAC_BITS - 1);
  localparam logic [ACC_H_W-1:0] ACC_H_MAX = ((ACC_H_W'(1) << ACC_W) - ACC_H_W'(1)) + HALF_H;
  localparam logic [ACC_H_W-1:0] ACC_H_RST = (ACC_H_W'(2) << FRAC_BITS) + HALF_H;

  // accumulators hold the running position plus one half, so the integer
  // part is the rounded target plus one
  logic [COORD_BITS-1:0] src_col_r, src_row_r, src_col_nxt, src_row_nxt;
  logic [D_W-1:0]        out_col_r, out_row_r, out_col_nxt, out_row_nxt;
  logic [ACC_H_W-1:0]    col_acc_r, row_acc_r, col_acc_nxt, row_acc_nxt;

  logic [COORD_BITS-1:0] sc_e, sr_e;
  logic [D_W-1:0]        oc_e, or_e;
  logic [ACC_H_W-1:0]    ca_e, ra_e;
  logic                  row_hit, col_hit;

  // saturating accumulate
  function automatic logic [ACC_H_W-1:0] acc_add(input logic [ACC_H_W-1:0] acc,
                                                 input logic [STEP_W-1:0]  step);
    logic [ACC_H_W:0] sum;
    sum = {1'b0, acc} + (ACC_H_W + 1)'(step);
    return (sum > {1'b0, ACC_H_MAX}) ? ACC_H_MAX : sum[ACC_H_W-1:0];
  endfunction

  // positions as seen by this pixel, after a frame restart
  always_comb begin
    sc_e = frame_start ? '0 : src_col_r;
    sr_e = frame_start ? '0 : src_row_r;
    oc_e = frame_start ? '0 : out_col_r;
    or_e = frame_start ? '0 : out_row_r;
    ca_e = frame_start ? col_step_h : col_acc_r;
    ra_e = frame_start ? row_step_h : row_acc_r;
  end

  // hit decision and end marks
  always_comb begin
    row_hit = ((D_W'(sr_e) + D_W'(1)) == ra_e[ACC_H_W-1:FRAC_BITS]) && (or_e < out_h);
    col_hit = ((D_W'(sc_e) + D_W'(1)) == ca_e[ACC_H_W-1:FRAC_BITS]) && (oc_e < out_w);
    res.hit       = row_hit && col_hit;
    res.row_end   = (oc_e == (out_w - D_W'(1)));
    res.frame_end = res.row_end && (or_e == (out_h - D_W'(1)));
  end

  // next positions
  always_comb begin
    src_col_nxt = sc_e + COORD_BITS'(1);
    src_row_nxt = sr_e;
    out_col_nxt = oc_e;
    out_row_nxt = or_e;
    col_acc_nxt = ca_e;
    row_acc_nxt = ra_e;
    if (row_hit && col_hit) begin
      out_col_nxt = oc_e + D_W'(1);
      col_acc_nxt = acc_add(ca_e, col_step);
    end
    // end of a source row
    if (sc_e >= src_w_m1) begin
      src_col_nxt = '0;
      out_col_nxt = '0;
      col_acc_nxt = col_step_h;
      if (row_hit) begin
        out_row_nxt = or_e + D_W'(1);
        row_acc_nxt = acc_add(ra_e, row_step);
      end
      // end of the source frame
      if (sr_e >= src_h_m1) begin
        src_row_nxt = '0;
        out_row_nxt = '0;
        row_acc_nxt = row_step_h;
      end else begin
        src_row_nxt = sr_e + COORD_BITS'(1);
      end
    end
  end

  // position registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r <= '0;
      src_row_r <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      col_acc_r <= ACC_H_RST;
      row_acc_r <= ACC_H_RST;
    end else if (step_en) begin
      src_col_r <= src_col_nxt;
      src_row_r <= src_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      col_acc_r <= col_acc_nxt;
      row_acc_r <= row_acc_nxt;
    end
  end

endmodule

/* rtl/nearest_neighbor_downscaler_core.sv */
// nearest_neighbor_downscaler_core: top level with input register, sampler
// and result register; depends on nnd_pkg, nnd_cfg_regs and nnd_sampler
//
//   channel | direction | handshake         | payload
//   in_     | input     | in_valid/in_ready | in_pixel_in, in_frame_start
//   out_    | output    | out_valid/out_ready | out_pixel_out, out_row_end,
//           |           |                   | out_frame_end
//   cfg_    | input     | cfg_wr_en         | cfg_index, cfg_data
//
// one pixel a cycle sustained while out_ready holds; a sampled pixel passes
// from the input register through the sampler's position-update logic into
// the result register, which drives out_valid.
// synchronous active-low reset; positions restart at reset, no clearing pass.
// a stalled result holds the result register; the input register still takes
// one more transaction, after which in_ready follows out_ready.
module nearest_neighbor_downscaler_core #(
  parameter int COORD_BITS = nnd_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = nnd_pkg::FRAC_BITS_DEF,
  parameter int CFG_DATA_W = ((4 + FRAC_BITS) > nnd_pkg::CFG_DIM_W) ?
                             (4 + FRAC_BITS) : nnd_pkg::CFG_DIM_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [nnd_pkg::PIX_W-1:0]     in_pixel_in,
  input  logic                          in_frame_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [nnd_pkg::PIX_W-1:0]     out_pixel_out,
  output logic                          out_row_end,
  output logic                          out_frame_end,
  input  logic                          cfg_wr_en,
  input  logic [nnd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);
  import nnd_pkg::*;

  localparam int STEP_W  = 4 + FRAC_BITS;
  localparam int D_W     = COORD_BITS + 1;
  localparam int ACC_H_W = COORD_BITS + FRAC_BITS + 1;

  logic [COORD_BITS-1:0] src_w_m1, src_h_m1;
  logic [D_W-1:0]        out_w, out_h;
  logic [STEP_W-1:0]     col_step, row_step;
  logic [ACC_H_W-1:0]    col_step_h, row_step_h;
  logic                  color_mode;

  logic              in_valid_r, in_fs_r, adv;
  logic [PIX_W-1:0]  in_pix_r, out_pix_nxt, out_pix_r;
  logic              out_valid_r, out_row_end_r, out_frame_end_r;
  sample_t           res;

  nnd_cfg_regs #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .CFG_DATA_W (CFG_DATA_W)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .src_w_m1   (src_w_m1),
    .src_h_m1   (src_h_m1),
    .out_w      (out_w),
    .out_h      (out_h),
    .col_step   (col_step),
    .row_step   (row_step),
    .col_step_h (col_step_h),
    .row_step_h (row_step_h),
    .color_mode (color_mode)
  );

  nnd_sampler #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_sampler (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (adv),
    .frame_start (in_fs_r),
    .src_w_m1    (src_w_m1),
    .src_h_m1    (src_h_m1),
    .out_w       (out_w),
    .out_h       (out_h),
    .col_step    (col_step),
    .row_step    (row_step),
    .col_step_h  (col_step_h),
    .row_step_h  (row_step_h),
    .res         (res)
  );

  // pipeline advance: the held pixel moves on when the result register frees
  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  // gray mode keeps one channel
  assign out_pix_nxt = color_mode ? in_pix_r : {{(PIX_W - CHAN_W){1'b0}}, in_pix_r[CHAN_W-1:0]};

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_pix_r <= in_pixel_in;
      in_fs_r  <= in_frame_start;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res.hit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.hit) begin
      out_pix_r       <= out_pix_nxt;
      out_row_end_r   <= res.row_end;
      out_frame_end_r <= res.frame_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pix_r;
  assign out_row_end   = out_row_end_r;
  assign out_frame_end = out_frame_end_r;

endmodule

/* rtl/nnd_checker.sv */
// nnd_checker: port-level assertions for the downscaler top level and the
// bind that attaches them; depends on nnd_pkg and the top level
module nnd_checker #(
  parameter int CFG_DATA_W = 20
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [nnd_pkg::PIX_W-1:0]     out_pixel_out,
  input logic                          out_row_end,
  input logic                          out_frame_end,
  input logic                          cfg_wr_en,
  input logic [nnd_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [CFG_DATA_W-1:0]         cfg_data
);
  import nnd_pkg::*;

  logic mode_r;

  // track colour mode from register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
    end else if (cfg_wr_en && (cfg_index == REG_COLOR_MODE)) begin
      mode_r <= cfg_data[0];
    end
  end

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_out)
      && $stable(out_row_end) && $stable(out_frame_end))
    else $error("stalled result changed");

  // the frame end is always also a row end
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_frame_end || out_row_end))
    else $error("frame end without row end");

  // gray mode clears the upper channels
  a_gray: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !mode_r |-> (out_pixel_out[PIX_W-1:CHAN_W] == '0))
    else $error("gray pixel with upper channels set");

  // with no result waiting the input side never stalls
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind nearest_neighbor_downscaler_core nnd_checker #(
  .CFG_DATA_W (CFG_DATA_W)
) u_nnd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_pixel_out (out_pixel_out),
  .out_row_end   (out_row_end),
  .out_frame_end (out_frame_end),
  .cfg_wr_en     (cfg_wr_en),
  .cfg_index     (cfg_index),
  .cfg_data      (cfg_data)
);
